[rtl/tlpw_pkg.sv]
// Shared constants for the two-level page walk block: table geometry, widths,
// operation and status codes, stream packing widths.
// No dependencies.
package tlpw_pkg;

  // Geometry
  localparam int NUM_TABLES    = 16;
  localparam int TABLE_ENTRIES = 1024;
  localparam int DIR_ENTRIES   = 1024;
  localparam int PAGE_BITS     = 12;                       // 4 KiB page offset
  localparam int PT_IDX_W      = $clog2(TABLE_ENTRIES);
  localparam int DIR_AW        = $clog2(DIR_ENTRIES);
  localparam int SLOT_W        = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int DIR_W         = SLOT_W + 1;               // present + slot
  localparam int FRAME_W       = 20;
  localparam int PTE_W         = FRAME_W + 1;              // present + frame
  localparam int STORE_DEPTH   = NUM_TABLES * TABLE_ENTRIES;
  localparam int STORE_AW      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CLR_W         = STORE_AW + 1;
  localparam int TU_W          = $clog2(NUM_TABLES + 1);
  localparam int FU_W          = 21;

  // Field widths
  localparam int VA_W     = 32;
  localparam int PA_W     = 32;
  localparam int STATUS_W = 2;
  localparam int TCNT_W   = 5;

  // Stream packing
  localparam int IN_TDATA_W  = 56;   // virt_address, spare_frame, pad
  localparam int OUT_TDATA_W = 64;   // phys, frame_taken, tables, frames, pad

  // Operation codes
  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_MAP       = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 2'd2;

endpackage

[rtl/tlpw_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module tlpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/two_level_page_walk_demand_map.sv]
// Top level of the two-level page walk with demand mapping.
// Depends on tlpw_pkg and tlpw_ram.
//
// Translates 32-bit virtual addresses through a 1024-entry page directory
// (4 MiB per entry) and up to NUM_TABLES page-table slots of 1024 entries
// (4 KiB pages). A translate request returns frame * 4096 + offset, or status
// "not mapped". A map request allocates the next free table slot when the
// directory entry is absent (status "out of table slots" when none is left),
// maps the page to in_tdata's spare frame when the page entry is absent, and
// then returns the translation. Every request gives exactly one result.
// After reset the block runs a clearing pass over both RAMs that writes the
// identity map of the first 4 MiB into slot zero and clears everything else;
// in_tready stays low during that pass. After that, one request at a time goes
// through a small sequencer around the two RAMs: accept and directory read,
// then page-table read (with any directory write-back), then page-table
// write-back and result. A request that ends at the directory level
// (translate of an absent directory entry, or no free slot) gives its result
// from the directory step. Each RAM has a registered read, and the directory
// read feeds the table read address. The result sits in an output register,
// so a stalled out_tready holds off only the next request, not the current
// one's work.
module two_level_page_walk_demand_map (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tlpw_pkg::IN_TDATA_W-1:0]     in_tdata,   // [31:0] virt_address,
                                                          // [51:32] spare_frame
  input  logic [0:0]                          in_tuser,   // [0] operation
  // Result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tlpw_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [31:0] phys_address,
                                                          // [32] frame_taken,
                                                          // [37:33] tables_in_use_count,
                                                          // [58:38] frames_in_use_count
  output logic [tlpw_pkg::STATUS_W-1:0]       out_tuser   // [1:0] status
);
  import tlpw_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,   // post-reset clearing pass over both RAMs
    S_IDLE,    // waiting for a request; directory read issued on accept
    S_DIR,     // directory entry available
    S_TBL,     // page-table entry available
    S_WAIT     // result computed, output register still occupied
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CLR_W-1:0]         clr_r, clr_nxt;

  // Request capture
  logic                     op_r, op_nxt;
  logic [VA_W-1:0]          virt_r, virt_nxt;
  logic [FRAME_W-1:0]       spare_r, spare_nxt;
  logic [SLOT_W-1:0]        slot_r, slot_nxt;

  // Counters
  logic [TU_W-1:0]          tables_used_r, tables_used_nxt;
  logic [FU_W-1:0]          frames_used_r, frames_used_nxt;

  // Parked result
  logic [PA_W-1:0]          res_phys_r, res_phys_nxt;
  logic [STATUS_W-1:0]      res_status_r, res_status_nxt;
  logic                     res_taken_r, res_taken_nxt;

  // Output register
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]   out_tdata_r, out_tdata_nxt;
  logic [STATUS_W-1:0]      out_tuser_r, out_tuser_nxt;

  // RAM ports
  logic                     dir_we;
  logic [DIR_AW-1:0]        dir_waddr, dir_raddr;
  logic [DIR_W-1:0]         dir_wdata, dir_rdata;
  logic                     tbl_we;
  logic [STORE_AW-1:0]      tbl_waddr, tbl_raddr;
  logic [PTE_W-1:0]         tbl_wdata, tbl_rdata;

  // Walk helpers
  logic                     pde_present;
  logic [SLOT_W-1:0]        slot_sel;
  logic                     pte_present;
  logic [FRAME_W-1:0]       frame_sel;
  logic                     out_free;
  logic                     res_done;
  logic [PA_W-1:0]          res_phys;
  logic [STATUS_W-1:0]      res_status;
  logic                     res_taken;

  tlpw_ram #(.WIDTH(DIR_W), .DEPTH(DIR_ENTRIES)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  tlpw_ram #(.WIDTH(PTE_W), .DEPTH(STORE_DEPTH)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_free   = !out_tvalid_r || out_tready;

  // Directory entry: present bit on top, slot below. An absent entry with a
  // free slot takes the next slot in order.
  assign pde_present = dir_rdata[DIR_W-1];
  assign slot_sel    = pde_present ? dir_rdata[SLOT_W-1:0] : SLOT_W'(tables_used_r);
  assign pte_present = tbl_rdata[PTE_W-1];

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    op_nxt          = op_r;
    virt_nxt        = virt_r;
    spare_nxt       = spare_r;
    slot_nxt        = slot_r;
    tables_used_nxt = tables_used_r;
    frames_used_nxt = frames_used_r;
    res_phys_nxt    = res_phys_r;
    res_status_nxt  = res_status_r;
    res_taken_nxt   = res_taken_r;
    out_tdata_nxt   = out_tdata_r;
    out_tuser_nxt   = out_tuser_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;

    dir_we    = 1'b0;
    dir_waddr = virt_r[VA_W-1 -: DIR_AW];
    dir_wdata = {1'b1, slot_sel};
    dir_raddr = in_tdata[VA_W-1 -: DIR_AW];
    tbl_we    = 1'b0;
    tbl_waddr = STORE_AW'({slot_r, virt_r[PAGE_BITS +: PT_IDX_W]});
    tbl_wdata = {1'b1, spare_r};
    tbl_raddr = STORE_AW'({slot_sel, virt_r[PAGE_BITS +: PT_IDX_W]});
    frame_sel = tbl_rdata[FRAME_W-1:0];

    res_done   = 1'b0;
    res_phys   = '0;
    res_status = ST_NOT_MAPPED;
    res_taken  = 1'b0;

    case (state_r)
      S_CLEAR: begin
        // Slot zero gets the identity map, the rest is cleared.
        tbl_we    = 1'b1;
        tbl_waddr = clr_r[STORE_AW-1:0];
        tbl_wdata = (clr_r < CLR_W'(TABLE_ENTRIES)) ? {1'b1, FRAME_W'(clr_r)} : '0;
        if (clr_r < CLR_W'(DIR_ENTRIES)) begin
          dir_we    = 1'b1;
          dir_waddr = clr_r[DIR_AW-1:0];
          dir_wdata = (clr_r == '0) ? {1'b1, {SLOT_W{1'b0}}} : '0;
        end
        clr_nxt = clr_r + CLR_W'(1);
        if (clr_r == CLR_W'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser[0];
          virt_nxt  = in_tdata[VA_W-1:0];
          spare_nxt = in_tdata[VA_W +: FRAME_W];
          state_nxt = S_DIR;
        end
      end

      S_DIR: begin
        slot_nxt = slot_sel;
        if (pde_present) begin
          state_nxt = S_TBL;
        end else if (op_r == OP_TRANSLATE) begin
          res_done   = 1'b1;
          res_status = ST_NOT_MAPPED;
        end else if (tables_used_r >= TU_W'(NUM_TABLES)) begin
          res_done   = 1'b1;
          res_status = ST_NO_SLOT;
        end else begin
          dir_we          = 1'b1;
          tables_used_nxt = tables_used_r + TU_W'(1);
          state_nxt       = S_TBL;
        end
      end

      S_TBL: begin
        res_done = 1'b1;
        if (!pte_present && op_r == OP_MAP) begin
          tbl_we          = 1'b1;
          frames_used_nxt = frames_used_r + FU_W'(1);
          frame_sel       = spare_r;
          res_taken       = 1'b1;
        end
        if (pte_present || op_r == OP_MAP) begin
          // Offset is below a page, so the add is a concatenation.
          res_phys   = {frame_sel, virt_r[PAGE_BITS-1:0]};
          res_status = ST_OK;
        end
      end

      S_WAIT: begin
        res_done   = 1'b1;
        res_phys   = res_phys_r;
        res_status = res_status_r;
        res_taken  = res_taken_r;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (res_done) begin
      res_phys_nxt   = res_phys;
      res_status_nxt = res_status;
      res_taken_nxt  = res_taken;
      if (out_free) begin
        out_tvalid_nxt = 1'b1;
        out_tuser_nxt  = res_status;
        out_tdata_nxt  = OUT_TDATA_W'({frames_used_nxt, TCNT_W'(tables_used_nxt),
                                       res_taken, res_phys});
        state_nxt      = S_IDLE;
      end else begin
        state_nxt = S_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      tables_used_r <= TU_W'(1);
      frames_used_r <= FU_W'(TABLE_ENTRIES);
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      tables_used_r <= tables_used_nxt;
      frames_used_r <= frames_used_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
    op_r         <= op_nxt;
    virt_r       <= virt_nxt;
    spare_r      <= spare_nxt;
    slot_r       <= slot_nxt;
    res_phys_r   <= res_phys_nxt;
    res_status_r <= res_status_nxt;
    res_taken_r  <= res_taken_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

endmodule

[sim/two_level_page_walk_demand_map_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for two_level_page_walk_demand_map: table-driven requests, then random ones,
// scored against typed results or a behavioral predictor. Depends on tlpw_pkg and the block's RTL.
module two_level_page_walk_demand_map_tb;
  import tlpw_pkg::*;

  localparam int RANDOM_REQUESTS = 1025;
  localparam int HOLD_OFF_AT     = 200;   // long receiver hold-off starts here
  localparam int DRAIN_AT        = 600;   // sender waits for every result here
  localparam int QUIET_AT        = 900;   // no idling on either side from here
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic               op;
    logic [VA_W-1:0]    va;
    logic [FRAME_W-1:0] spare;
  } walk_request_t;

  typedef struct packed {
    logic [PA_W-1:0]     phys;
    logic [STATUS_W-1:0] status;
    logic                taken;
    logic [TCNT_W-1:0]   tables;
    logic [FU_W-1:0]     frames;
  } walk_result_t;

  // Directed row: result is typed in only where it is obvious by inspection.
  typedef struct {
    walk_request_t req;
    bit            typed;
    walk_result_t  want;
  } walk_vector_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // [31:0] virt_address, [51:32] spare_frame
  logic [0:0]             in_tuser   = '0;  // [0] operation
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [31:0] phys, [32] frame_taken,
                                            // [37:33] tables, [58:38] frames
  logic [STATUS_W-1:0]    out_tuser;        // [1:0] status

  two_level_page_walk_demand_map dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Page-walk predictor state: directory (present + slot), slot store
  // (present + frame), allocation counters, and the list of directory
  // indexes that currently have a table (used to steer random requests).
  // ---------------------------------------------------------------------------
  logic              dir_present [DIR_ENTRIES];
  logic [SLOT_W-1:0] dir_slot    [DIR_ENTRIES];
  logic              pte_present [STORE_DEPTH];
  logic [FRAME_W-1:0] pte_frame  [STORE_DEPTH];
  int unsigned       tables_used;
  int unsigned       frames_used;
  int unsigned       mapped_dirs [$];

  walk_result_t  pending_translations [$];   // expected results, oldest first
  walk_vector_t  directed_rows [$];
  int            mismatch_count = 0;
  bit            hold_off_req   = 1'b0;
  bit            quiet_phase    = 1'b0;

  // Walk one request through the predictor; updates state like the block does.
  function automatic walk_result_t compute_translation(walk_request_t r);
    walk_result_t          rsp;
    logic [DIR_AW-1:0]     di;
    logic [PT_IDX_W-1:0]   ti;
    int unsigned           idx;
    bit                    walk;
    rsp        = '0;
    rsp.status = ST_NOT_MAPPED;
    di         = r.va[31:22];
    ti         = r.va[21:12];
    walk       = 1'b1;
    if (!dir_present[di]) begin
      if (r.op == OP_MAP) begin
        if (tables_used >= NUM_TABLES) begin
          rsp.status = ST_NO_SLOT;
          walk       = 1'b0;
        end else begin
          // slots handed out in order; a fresh slot is still cleared
          dir_present[di] = 1'b1;
          dir_slot[di]    = SLOT_W'(tables_used);
          tables_used++;
          mapped_dirs.push_back(32'(di));
        end
      end else begin
        walk = 1'b0;
      end
    end
    if (walk) begin
      idx = dir_slot[di] * TABLE_ENTRIES + ti;
      if (!pte_present[idx] && r.op == OP_MAP) begin
        pte_present[idx] = 1'b1;
        pte_frame[idx]   = r.spare;
        frames_used++;
        rsp.taken = 1'b1;
      end
      if (pte_present[idx]) begin
        rsp.phys   = {pte_frame[idx], r.va[PAGE_BITS-1:0]};
        rsp.status = ST_OK;
      end
    end
    rsp.tables = tables_used[TCNT_W-1:0];
    rsp.frames = frames_used[FU_W-1:0];
    return rsp;
  endfunction

  function automatic void push_row(logic op, logic [VA_W-1:0] va, logic [FRAME_W-1:0] spare,
                                   bit typed, logic [PA_W-1:0] phys,
                                   logic [STATUS_W-1:0] st, logic taken,
                                   logic [TCNT_W-1:0] tables, logic [FU_W-1:0] frames);
    walk_vector_t v;
    v.req   = '{op: op, va: va, spare: spare};
    v.typed = typed;
    v.want  = '{phys: phys, status: st, taken: taken, tables: tables, frames: frames};
    directed_rows.push_back(v);
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Random gap in the request stream; valid drops, except in the quiet phase.
  task automatic maybe_idle();
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Offer one request and hold it until accepted. Valid is left high so a
  // back-to-back request does not toggle it within one time step.
  task automatic send_request(walk_request_t r, bit typed, walk_result_t want);
    walk_result_t predicted;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - FRAME_W - VA_W){1'b0}}, r.spare, r.va};
    in_tuser  <= r.op;
    do @(posedge clk); while (!in_tready);
    // predictor always runs so its state tracks the block
    predicted = compute_translation(r);
    pending_translations.push_back(typed ? want : predicted);
  endtask

  // ---------------------------------------------------------------------------
  // Request source: reset, directed table, random requests, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin : request_source
    walk_request_t       r;
    logic [DIR_AW-1:0]   di;
    logic [PT_IDX_W-1:0] ti;

    // predictor reset: first 4 MiB identity-mapped through slot zero
    foreach (dir_present[i]) begin
      dir_present[i] = 1'b0;
      dir_slot[i]    = '0;
    end
    foreach (pte_present[i]) begin
      pte_present[i] = (i < TABLE_ENTRIES);
      pte_frame[i]   = (i < TABLE_ENTRIES) ? FRAME_W'(i) : '0;
    end
    dir_present[0] = 1'b1;
    tables_used    = 1;
    frames_used    = TABLE_ENTRIES;
    mapped_dirs.push_back(0);

    // identity map, its edges, and an address with no directory entry
    push_row(OP_TRANSLATE, 32'h0000_0000, 20'h00000, 1, 32'h0000_0000, ST_OK,         0, 1, 1024);
    push_row(OP_TRANSLATE, 32'h003F_FFFF, 20'h00000, 1, 32'h003F_FFFF, ST_OK,         0, 1, 1024);
    push_row(OP_TRANSLATE, 32'hFFFF_FFFF, 20'hFFFFF, 1, 32'h0000_0000, ST_NOT_MAPPED, 0, 1, 1024);
    // map of a present page ignores the spare frame
    push_row(OP_MAP,       32'h0000_1234, 20'hFFFFF, 1, 32'h0000_1234, ST_OK,         0, 1, 1024);
    // new slot plus new frame at the top of the address space
    push_row(OP_MAP,       32'hFFFF_FFFF, 20'hFFFFF, 1, 32'hFFFF_FFFF, ST_OK,         1, 2, 1025);
    push_row(OP_MAP,       32'hFFFF_F000, 20'h00000, 1, 32'hFFFF_F000, ST_OK,         0, 2, 1025);
    // new frame in an existing slot, frame number zero
    push_row(OP_MAP,       32'hFFC0_0000, 20'h00000, 1, 32'h0000_0000, ST_OK,         1, 2, 1026);
    push_row(OP_TRANSLATE, 32'hFFC0_0ABC, 20'h00000, 1, 32'h0000_0ABC, ST_OK,         0, 2, 1026);
    // directory present but page absent
    push_row(OP_TRANSLATE, 32'hFFC0_1000, 20'h00000, 1, 32'h0000_0000, ST_NOT_MAPPED, 0, 2, 1026);
    push_row(OP_MAP,       32'h8000_0000, 20'hAAAAA, 1, 32'hAAAA_A000, ST_OK,         1, 3, 1027);
    push_row(OP_MAP,       32'h8040_0555, 20'h55555, 1, 32'h5555_5555, ST_OK,         1, 4, 1028);
    // use up the remaining slots
    for (int k = 0; k < NUM_TABLES - 4; k++)
      push_row(OP_MAP, {10'(10'h100 + k), 22'h15_5555}, 20'(32'h1F00 + 7 * k), 0, '0, '0, 0, 0, 0);
    // no slot left: map fails, then translate of the same address misses
    push_row(OP_MAP,       32'h7FC0_0000, 20'h12345, 1, 32'h0000_0000, ST_NO_SLOT,    0, 16, 1040);
    push_row(OP_TRANSLATE, 32'h7FC0_0000, 20'h12345, 1, 32'h0000_0000, ST_NOT_MAPPED, 0, 16, 1040);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // in_tready stays low through the clearing pass; send_request just waits

    foreach (directed_rows[i]) begin
      maybe_idle();
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == HOLD_OFF_AT) hold_off_req = 1'b1;
      if (n == DRAIN_AT) begin
        // pause until the block has returned everything
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_translations.size() != 0) @(posedge clk);
      end
      if (n == QUIET_AT) quiet_phase = 1'b1;
      maybe_idle();
      // mostly hit directories that have a table and a few low pages, so
      // maps land on pages that later requests revisit
      if ($urandom_range(0, 9) < 7)
        di = DIR_AW'(mapped_dirs[$urandom_range(0, mapped_dirs.size() - 1)]);
      else
        di = DIR_AW'($urandom_range(0, DIR_ENTRIES - 1));
      if ($urandom_range(0, 1) == 0)
        ti = PT_IDX_W'($urandom_range(0, 7));
      else
        ti = PT_IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));
      r.op    = ($urandom_range(0, 9) < 6) ? OP_MAP : OP_TRANSLATE;
      r.va    = {di, ti, 12'($urandom_range(0, 4095))};
      r.spare = FRAME_W'($urandom_range(0, (1 << FRAME_W) - 1));
      send_request(r, 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (pending_translations.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);   // catch any stray extra result
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts, one long hold-off so the block backs up
  // into its request side, always ready once the quiet phase starts.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    bit hold_off_done;
    hold_off_done = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Score every accepted result against the oldest expectation.
  always @(posedge clk) begin : result_check
    walk_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_translations.size() == 0) begin
        flag_mismatch("unexpected result", out_tdata[31:0], '0);
      end else begin
        want = pending_translations.pop_front();
        if (out_tdata[31:0] !== want.phys)
          flag_mismatch("phys_address", out_tdata[31:0], want.phys);
        if (out_tuser !== want.status)
          flag_mismatch("status", 32'(out_tuser), 32'(want.status));
        if (out_tdata[32] !== want.taken)
          flag_mismatch("frame_taken", 32'(out_tdata[32]), 32'(want.taken));
        if (out_tdata[37:33] !== want.tables)
          flag_mismatch("tables_in_use_count", 32'(out_tdata[37:33]), 32'(want.tables));
        if (out_tdata[58:38] !== want.frames)
          flag_mismatch("frames_in_use_count", 32'(out_tdata[58:38]), 32'(want.frames));
      end
    end
  end

  // Watchdog: covers the clearing pass plus worst-case gaps and stalls many times over.
  initial begin : watchdog
    #(64'd4_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

[files.f]
rtl/tlpw_pkg.sv
rtl/tlpw_ram.sv
rtl/two_level_page_walk_demand_map.sv
sim/two_level_page_walk_demand_map_tb.sv
